// File: hdl/jms_pkg.sv
// Types and constants shared by the JPEG marker segment parser files.
package jms_pkg;

    localparam logic [7:0] PREFIX_BYTE = 8'hFF;
    localparam logic [7:0] MARK_SOI    = 8'hD8;
    localparam logic [7:0] MARK_EOI    = 8'hD9;
    localparam logic [7:0] MARK_SOS    = 8'hDA;
    localparam logic [15:0] LEN_HEADER = 16'd2;

    typedef enum logic [2:0] {
        PH_PREFIX  = 3'd0,
        PH_MARKER  = 3'd1,
        PH_LEN_HI  = 3'd2,
        PH_LEN_LO  = 3'd3,
        PH_PAYLOAD = 3'd4,
        PH_ENTROPY = 3'd5,
        PH_HALTED  = 3'd6
    } t_phase;

    typedef enum logic [1:0] {
        ST_OK         = 2'd0,
        ST_BAD_PREFIX = 2'd1,
        ST_TRUNCATED  = 2'd2
    } t_status;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       forward;
        logic [2:0] phase;
        logic [7:0] segment_marker;
        logic [1:0] status;
    } t_result;

endpackage

// File: hdl/jms_in_if.sv
// Input byte channel of the JPEG marker segment parser.
interface jms_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       last;

    modport source (output valid, output data_byte, output last, input ready);
    modport sink (input valid, input data_byte, input last, output ready);
endinterface

// File: hdl/jms_out_if.sv
// Result channel of the JPEG marker segment parser.
interface jms_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] out_byte;
    logic       forward;
    logic [2:0] phase;
    logic [7:0] segment_marker;
    logic [1:0] status;

    modport source (output valid, output out_byte, output forward, output phase,
                    output segment_marker, output status, input ready);
    modport sink (input valid, input out_byte, input forward, input phase,
                  input segment_marker, input status, output ready);
endinterface

// File: hdl/jpeg_marker_segment_parser.sv
// Top level of the JPEG marker segment parser: input register, parse core, result register.
//
//   Channel | Direction | Payload
//   i_in    | in        | data_byte[7:0], last
//   o_out   | out       | out_byte[7:0], forward, phase[2:0], segment_marker[7:0], status[1:0]
//
// One byte is accepted per cycle while i_in.ready is high. Its result passes through
// the input register and then the result register before it is offered on o_out.
// The parse state advances as a byte moves from the input register into the
// result register. Reset clears the parse state and both valid flags. A stalled
// output holds the result register and the input register in turn; both fill
// before i_in.ready drops.
module jpeg_marker_segment_parser import jms_pkg::*; (
    input  logic         i_clk,
    input  logic         i_rst_n,
    jms_in_if.sink       i_in,
    jms_out_if.source    o_out
);

    logic       r_in_valid;
    logic [7:0] r_in_byte;
    logic       r_in_last;
    logic       r_out_valid;
    t_result    r_out;
    t_result    core_result;
    logic       out_free;
    logic       step;
    logic       in_take;

    assign out_free = !r_out_valid || o_out.ready;
    assign step     = r_in_valid && out_free;
    assign i_in.ready = !r_in_valid || out_free;
    assign in_take  = i_in.valid && i_in.ready;

    jms_parse_core u_core (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_step      (step),
        .i_data_byte (r_in_byte),
        .i_last      (r_in_last),
        .o_result    (core_result)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (in_take) begin
                r_in_valid <= 1'b1;
            end else if (step) begin
                r_in_valid <= 1'b0;
            end
            if (step) begin
                r_out_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_in_byte <= i_in.data_byte;
            r_in_last <= i_in.last;
        end
        if (step) begin
            r_out <= core_result;
        end
    end

    assign o_out.valid          = r_out_valid;
    assign o_out.out_byte       = r_out.out_byte;
    assign o_out.forward        = r_out.forward;
    assign o_out.phase          = r_out.phase;
    assign o_out.segment_marker = r_out.segment_marker;
    assign o_out.status         = r_out.status;

endmodule

// File: hdl/jms_parse_core.sv
// Parser state registers and the per-byte state update and result logic.
module jms_parse_core import jms_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_step,
    input  logic [7:0] i_data_byte,
    input  logic       i_last,
    output t_result    o_result
);

    t_phase      r_phase, n_phase;
    logic [7:0]  r_marker, n_marker;
    logic [7:0]  r_len_hi, n_len_hi;
    logic [15:0] r_left, n_left;
    t_status     r_err, n_err;

    logic        halted;
    logic        bad_prefix;
    logic [15:0] seg_len;
    logic [15:0] left_dec;
    t_phase      p_phase;
    logic [7:0]  p_marker;
    logic [7:0]  p_len_hi;
    logic [15:0] p_left;
    logic        clean_end;

    assign halted     = (r_err != ST_OK) || (r_phase == PH_HALTED);
    assign bad_prefix = (r_phase == PH_PREFIX) && (i_data_byte != PREFIX_BYTE);
    assign seg_len    = {r_len_hi, i_data_byte};
    assign left_dec   = (r_left != 16'd0) ? r_left - 16'd1 : r_left;

    // Phase, marker, length and remaining count after the byte itself, before the end-of-stream check.
    always_comb begin
        p_phase  = r_phase;
        p_marker = r_marker;
        p_len_hi = r_len_hi;
        p_left   = r_left;
        unique case (r_phase)
            PH_PREFIX: begin
                p_phase = bad_prefix ? PH_HALTED : PH_MARKER;
            end
            PH_MARKER: begin
                p_marker = i_data_byte;
                if (i_data_byte == MARK_SOI || i_data_byte == MARK_EOI) begin
                    p_phase = PH_PREFIX;
                end else begin
                    p_phase = PH_LEN_HI;
                end
            end
            PH_LEN_HI: begin
                p_len_hi = i_data_byte;
                p_phase  = PH_LEN_LO;
            end
            PH_LEN_LO: begin
                if (r_marker == MARK_SOS) begin
                    p_phase = PH_ENTROPY;
                end else if (seg_len > LEN_HEADER) begin
                    p_left  = seg_len - LEN_HEADER;
                    p_phase = PH_PAYLOAD;
                end else begin
                    p_phase = PH_PREFIX;
                end
            end
            PH_PAYLOAD: begin
                p_left = left_dec;
                if (left_dec == 16'd0) begin
                    p_phase = PH_PREFIX;
                end
            end
            PH_ENTROPY: begin
                p_phase = PH_ENTROPY;
            end
            default: begin
                p_phase = PH_HALTED;
            end
        endcase
    end

    assign clean_end = (p_phase == PH_ENTROPY) ||
                       ((p_phase == PH_PREFIX) && (p_marker == MARK_EOI));

    // Next state, including the halt and the return to reset values at a clean end.
    always_comb begin
        n_phase  = p_phase;
        n_marker = p_marker;
        n_len_hi = p_len_hi;
        n_left   = p_left;
        n_err    = r_err;
        if (halted) begin
            n_phase  = PH_HALTED;
            n_marker = r_marker;
            n_len_hi = r_len_hi;
            n_left   = r_left;
        end else if (bad_prefix) begin
            n_err = ST_BAD_PREFIX;
        end else if (i_last) begin
            if (clean_end) begin
                n_phase  = PH_PREFIX;
                n_marker = MARK_SOI;
                n_len_hi = 8'd0;
                n_left   = 16'd0;
            end else begin
                n_phase = PH_HALTED;
                n_err   = ST_TRUNCATED;
            end
        end
    end

    // Result fields for the byte.
    always_comb begin
        o_result.out_byte = i_data_byte;
        o_result.status   = n_err;
        if (halted || bad_prefix) begin
            o_result.forward        = 1'b0;
            o_result.phase          = PH_HALTED;
            o_result.segment_marker = 8'd0;
        end else begin
            o_result.forward        = 1'b1;
            o_result.phase          = r_phase;
            o_result.segment_marker = (r_phase == PH_PREFIX) ? 8'd0 : p_marker;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase  <= PH_PREFIX;
            r_marker <= MARK_SOI;
            r_len_hi <= 8'd0;
            r_left   <= 16'd0;
            r_err    <= ST_OK;
        end else if (i_step) begin
            r_phase  <= n_phase;
            r_marker <= n_marker;
            r_len_hi <= n_len_hi;
            r_left   <= n_left;
            r_err    <= n_err;
        end
    end

endmodule
